@@ sv/rvm_pkg.sv @@
// shared types and constants for the resampling voice mixer
`default_nettype none
package rvm_pkg;

	localparam int ADDR_BITS      = 12;
	localparam int SAMPLE_DEPTH   = 1 << ADDR_BITS;
	localparam int SAMPLE_BITS    = 16;
	localparam int FRACTION_BITS  = 32;
	localparam int POS_BITS       = ADDR_BITS + FRACTION_BITS;
	localparam int INTERP_SHIFT   = 16;
	localparam int VOLUME_DIVISOR = 64;
	localparam int VOLUME_BITS    = 16;
	localparam int RAMP_BITS      = 23;
	localparam int ACC_BITS       = 32;
	localparam int CFG_DATA_BITS  = POS_BITS;

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_START = 2'd1,
		OP_MIX   = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		MODE_MONO     = 2'd0,
		MODE_STEREO   = 2'd1,
		MODE_SURROUND = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		CFG_MIX_MODE        = 3'd0,
		CFG_INTERPOLATE     = 3'd1,
		CFG_DECLICK         = 3'd2,
		CFG_STEP_INCREMENT  = 3'd3,
		CFG_LEFT_VOLUME     = 3'd4,
		CFG_RIGHT_VOLUME    = 3'd5,
		CFG_LEFT_RAMP_STEP  = 3'd6,
		CFG_RIGHT_RAMP_STEP = 3'd7
	} cfg_idx_t;

	localparam logic [POS_BITS-1:0] STEP_RESET = POS_BITS'(64'd1 << FRACTION_BITS);

endpackage
`default_nettype wire

@@ sv/resampling_voice_mixer_core.sv @@
// resampling voice mixer: sample memory, voice state and mixing datapath
// load and start requests take effect when accepted; a mix request is read
// from the sample memory, interpolated, scaled and accumulated in stages (s1
// read, s2 interpolation product and volume, s3 scaled terms, then output register)
// a new request is taken each cycle after load/start, none while s1-s3 hold a mix
// arst_n clears voice state, configuration to its defaults and all valids;
// sample memory contents are not cleared
`default_nettype none
module resampling_voice_mixer_core (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_we,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [43:0]  cfg_data,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// sample_address, sample_value, start_position, start_left_volume,
	// start_right_volume, dest_left_in, dest_right_in, 2 zero bits
	input  wire logic [183:0] s_tdata,
	// operation
	input  wire logic [1:0]   s_tuser,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// mixed_left, mixed_right
	output logic [63:0]       m_tdata
);

	localparam int AB = rvm_pkg::ADDR_BITS;
	localparam int SB = rvm_pkg::SAMPLE_BITS;
	localparam int PB = rvm_pkg::POS_BITS;
	localparam int FB = rvm_pkg::FRACTION_BITS;
	localparam int IS = rvm_pkg::INTERP_SHIFT;
	localparam int RB = rvm_pkg::RAMP_BITS;
	localparam int VB = rvm_pkg::VOLUME_BITS;
	localparam int CB = rvm_pkg::ACC_BITS;
	localparam int PRODB = SB + IS + 2;
	localparam int LVB = RB + 1;

	// request fields
	rvm_pkg::op_t            in_op;
	logic [AB-1:0]           in_addr;
	logic [SB-1:0]           in_value;
	logic [PB-1:0]           in_pos;
	logic [RB-1:0]           in_lvol;
	logic [RB-1:0]           in_rvol;
	logic [CB-1:0]           in_accl;
	logic [CB-1:0]           in_accr;

	assign in_op    = rvm_pkg::op_t'(s_tuser);
	assign in_addr  = s_tdata[11:0];
	assign in_value = s_tdata[27:12];
	assign in_pos   = s_tdata[71:28];
	assign in_lvol  = s_tdata[94:72];
	assign in_rvol  = s_tdata[117:95];
	assign in_accl  = s_tdata[149:118];
	assign in_accr  = s_tdata[181:150];

	// configuration
	rvm_pkg::mode_t          mode_q;
	logic                    interp_q;
	logic                    declick_q;
	logic [PB-1:0]           step_q;
	logic [VB-1:0]           lvol_q;
	logic [VB-1:0]           rvol_q;
	logic [RB-1:0]           lstep_q;
	logic [RB-1:0]           rstep_q;

	// voice state
	logic [PB-1:0]           pos_q;
	logic signed [RB-1:0]    lramp_q;
	logic signed [RB-1:0]    rramp_q;

	// sample memory
	logic [SB-1:0]           mem [rvm_pkg::SAMPLE_DEPTH];
	logic signed [SB-1:0]    rd0_q;
	logic signed [SB-1:0]    rd1_q;
	logic [AB-1:0]           rd_addr;

	// pipeline
	logic                    v_s1, v_s2, v_s3;
	logic [IS-1:0]           weight_s1;
	logic [CB-1:0]           accl_s1, accr_s1, accl_s2, accr_s2, accl_s3, accr_s3;
	logic signed [SB-1:0]    s0_s2;
	logic signed [PRODB-1:0] prod_s2;
	logic signed [LVB-1:0]   lv_s2, rv_s2;
	logic [CB-1:0]           lterm_s3, rterm_s3;

	logic                    accept, mix_req, stereo, mono, out_free;
	logic signed [SB:0]      diff;
	logic signed [PRODB-1:0] diff_ext, weight_ext, prod;
	logic signed [RB-1:0]    lramp_div, rramp_div;
	logic signed [LVB-1:0]   lv, rv;
	logic signed [PRODB-1:0] interp_sum;
	logic signed [SB-1:0]    smp;
	logic signed [LVB+SB-1:0] lprod, rprod;
	logic [CB-1:0]           mix_l, mix_r;

	assign s_tready = !(v_s1 || v_s2 || v_s3);
	assign accept   = s_tvalid && s_tready;
	assign mix_req  = accept && (in_op == rvm_pkg::OP_MIX);
	assign stereo   = (mode_q == rvm_pkg::MODE_STEREO);
	assign mono     = (mode_q == rvm_pkg::MODE_MONO);
	assign out_free = !m_tvalid || m_tready;
	assign rd_addr  = pos_q[PB-1:FB];

	always_ff @(posedge clk) begin
		if (accept && (in_op == rvm_pkg::OP_LOAD)) begin
			mem[in_addr] <= in_value;
		end
		rd0_q <= mem[rd_addr];
		rd1_q <= mem[AB'(rd_addr + 1'b1)];
	end

	// s1: interpolation product and volume selection
	assign diff       = {rd1_q[SB-1], rd1_q} - {rd0_q[SB-1], rd0_q};
	assign diff_ext   = PRODB'(diff);
	assign weight_ext = PRODB'({1'b0, weight_s1});
	assign prod       = diff_ext * weight_ext;
	assign lramp_div  = RB'(lramp_q / rvm_pkg::VOLUME_DIVISOR);
	assign rramp_div  = RB'(rramp_q / rvm_pkg::VOLUME_DIVISOR);
	assign lv = declick_q ? LVB'(lramp_div) : LVB'({1'b0, lvol_q});
	assign rv = declick_q ? LVB'(rramp_div) : LVB'({1'b0, rvol_q});

	// s2: interpolated sample, scaled terms
	assign interp_sum = PRODB'(s0_s2) + (prod_s2 >>> IS);
	assign smp   = interp_q ? SB'(interp_sum) : s0_s2;
	assign lprod = LVB'(lv_s2) * smp;
	assign rprod = LVB'(rv_s2) * smp;

	// s3: accumulate
	always_comb begin
		mix_l = accl_s3 + lterm_s3;
		if (stereo) begin
			mix_r = accr_s3 + rterm_s3;
		end else if (mono) begin
			mix_r = accr_s3;
		end else begin
			mix_r = accr_s3 - lterm_s3;
		end
	end

	always_ff @(posedge clk) begin
		weight_s1 <= pos_q[FB-1 -: IS];
		if (mix_req) begin
			accl_s1 <= in_accl;
			accr_s1 <= in_accr;
		end
		s0_s2    <= rd0_q;
		prod_s2  <= prod;
		lv_s2    <= lv;
		rv_s2    <= rv;
		accl_s2  <= accl_s1;
		accr_s2  <= accr_s1;
		if (v_s2) begin
			lterm_s3 <= lprod[CB-1:0];
			rterm_s3 <= rprod[CB-1:0];
			accl_s3  <= accl_s2;
			accr_s3  <= accr_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= rvm_pkg::MODE_STEREO;
			interp_q  <= 1'b1;
			declick_q <= 1'b0;
			step_q    <= rvm_pkg::STEP_RESET;
			lvol_q    <= '0;
			rvol_q    <= '0;
			lstep_q   <= '0;
			rstep_q   <= '0;
		end else if (cfg_we) begin
			case (rvm_pkg::cfg_idx_t'(cfg_index))
				rvm_pkg::CFG_MIX_MODE:        mode_q    <= rvm_pkg::mode_t'(cfg_data[1:0]);
				rvm_pkg::CFG_INTERPOLATE:     interp_q  <= cfg_data[0];
				rvm_pkg::CFG_DECLICK:         declick_q <= cfg_data[0];
				rvm_pkg::CFG_STEP_INCREMENT:  step_q    <= cfg_data[PB-1:0];
				rvm_pkg::CFG_LEFT_VOLUME:     lvol_q    <= cfg_data[VB-1:0];
				rvm_pkg::CFG_RIGHT_VOLUME:    rvol_q    <= cfg_data[VB-1:0];
				rvm_pkg::CFG_LEFT_RAMP_STEP:  lstep_q   <= cfg_data[RB-1:0];
				rvm_pkg::CFG_RIGHT_RAMP_STEP: rstep_q   <= cfg_data[RB-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			lramp_q <= '0;
			rramp_q <= '0;
		end else if (accept) begin
			case (in_op)
				rvm_pkg::OP_START: begin
					pos_q   <= in_pos;
					lramp_q <= in_lvol;
					rramp_q <= in_rvol;
				end
				rvm_pkg::OP_MIX: begin
					// position wraps at the memory span, which is the full register width
					pos_q <= pos_q + step_q;
					if (declick_q) begin
						lramp_q <= lramp_q + lstep_q;
						if (stereo) begin
							rramp_q <= rramp_q + rstep_q;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			v_s1 <= mix_req;
			v_s2 <= v_s1;
			if (v_s2) begin
				v_s3 <= 1'b1;
			end else if (v_s3 && out_free) begin
				v_s3 <= 1'b0;
			end
			if (v_s3 && out_free) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (v_s3 && out_free) begin
			m_tdata <= {mix_r, mix_l};
		end
	end

`ifndef SYNTHESIS
	// only one mix request in flight
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({v_s1, v_s2, v_s3}))
		else $error("more than one mix request in flight");

	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !(v_s1 || v_s2 || v_s3))
		else $error("ready while pipeline busy");

	a_mix_enters: assert property (@(posedge clk) disable iff (!arst_n)
		mix_req |=> v_s1 && !s_tready)
		else $error("mix request did not enter pipeline");

	a_s1_to_s3: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |=> ##1 v_s3)
		else $error("mix request lost between stages");

	a_s3_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && out_free) |=> m_tvalid && !v_s3)
		else $error("result not moved to output");
`endif

endmodule
`default_nettype wire

@@ tb/tb_resampling_voice_mixer_core.sv @@
// self-checking testbench for the resampling voice mixer core, directed and random requests
module tb_resampling_voice_mixer_core;

	localparam logic [1:0] OP_UNUSED         = 2'd3;
	localparam logic [1:0] MODE_SURROUND_ALT = 2'd3;
	localparam int         GAP_LIMIT         = 17;
	localparam int         DRAIN_CYCLES      = 12;
	localparam int         HOLD_CYCLES       = 400;

	// request payload, last declared field in the lowest bits
	typedef struct packed {
		logic [1:0]         zero_pad;
		logic signed [31:0] dest_right;
		logic signed [31:0] dest_left;
		logic signed [22:0] start_rvol;
		logic signed [22:0] start_lvol;
		logic [43:0]        start_pos;
		logic signed [15:0] sample;
		logic [11:0]        addr;
	} voice_req_t;

	typedef struct packed {
		logic [31:0] mixed_right;
		logic [31:0] mixed_left;
	} mix_out_t;

	typedef struct packed {
		logic [1:0]         mode;
		logic               interp;
		logic               declick;
		logic [43:0]        step;
		logic [15:0]        lvol;
		logic [15:0]        rvol;
		logic signed [22:0] lramp_step;
		logic signed [22:0] rramp_step;
	} voice_cfg_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         cfg_we = 1'b0;
	logic [2:0]   cfg_index = rvm_pkg::CFG_MIX_MODE;
	logic [43:0]  cfg_data = '0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [183:0] s_tdata = '0;
	logic [1:0]   s_tuser = rvm_pkg::OP_LOAD;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [63:0]  m_tdata;

	// shadow of the voice: sample words, play position, ramps and registers
	logic signed [15:0] sample_words [rvm_pkg::SAMPLE_DEPTH];
	bit                 word_written [rvm_pkg::SAMPLE_DEPTH];
	logic [43:0]        voice_pos = '0;
	logic signed [22:0] ramp_l = '0;
	logic signed [22:0] ramp_r = '0;
	voice_cfg_t         cur_cfg = '{mode: rvm_pkg::MODE_STEREO, interp: 1'b1, declick: 1'b0,
		step: rvm_pkg::STEP_RESET, lvol: '0, rvol: '0, lramp_step: '0, rramp_step: '0};

	mix_out_t expected_mix_q [$];
	int       error_count = 0;
	int       tx_gap_max = 0;
	int       rx_gap_max = 0;
	bit       rx_hold_on = 1'b0;
	int       rx_hold_count = 0;

	resampling_voice_mixer_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	task automatic report_error(input string msg);
		error_count++;
		$display("error at %0t: %s", $time, msg);
	endtask

	// expected effect of one accepted request
	task automatic apply_voice_request(input logic [1:0] op, input voice_req_t req);
		logic [11:0]        idx;
		logic [11:0]        nidx;
		logic signed [15:0] smp;
		longint             cur;
		longint             nxt;
		longint             weight;
		longint             lv;
		longint             rv;
		logic [31:0]        lterm;
		mix_out_t           res;
		case (op)
			rvm_pkg::OP_LOAD: begin
				sample_words[req.addr] = req.sample;
				word_written[req.addr] = 1'b1;
			end
			rvm_pkg::OP_START: begin
				voice_pos = req.start_pos;
				ramp_l = req.start_lvol;
				ramp_r = req.start_rvol;
			end
			rvm_pkg::OP_MIX: begin
				idx = voice_pos[43:32];
				nidx = idx + 12'd1;
				smp = sample_words[idx];
				if (cur_cfg.interp) begin
					cur = smp;
					nxt = sample_words[nidx];
					weight = voice_pos[31:16];
					// floor of the weighted difference, then wrap back to 16 bits
					smp = 16'(cur + (((nxt - cur) * weight) >>> rvm_pkg::INTERP_SHIFT));
				end
				if (cur_cfg.declick) begin
					ramp_l = ramp_l + cur_cfg.lramp_step;
					if (cur_cfg.mode == rvm_pkg::MODE_STEREO)
						ramp_r = ramp_r + cur_cfg.rramp_step;
					lv = ramp_l;
					rv = ramp_r;
					lv = lv / rvm_pkg::VOLUME_DIVISOR;
					rv = rv / rvm_pkg::VOLUME_DIVISOR;
				end else begin
					lv = cur_cfg.lvol;
					rv = cur_cfg.rvol;
				end
				lterm = 32'(lv * smp);
				res.mixed_left = req.dest_left + lterm;
				case (cur_cfg.mode)
					rvm_pkg::MODE_MONO:   res.mixed_right = req.dest_right;
					rvm_pkg::MODE_STEREO: res.mixed_right = req.dest_right + 32'(rv * smp);
					default:              res.mixed_right = req.dest_right - lterm;
				endcase
				voice_pos = voice_pos + cur_cfg.step;
				expected_mix_q.push_back(res);
			end
			default: ;
		endcase
	endtask

	function automatic voice_req_t random_req();
		voice_req_t r;
		r.zero_pad = '0;
		r.addr = 12'($urandom);
		r.sample = 16'($urandom);
		r.start_pos = {12'($urandom), $urandom};
		r.start_lvol = 23'($urandom);
		r.start_rvol = 23'($urandom);
		r.dest_left = $urandom;
		r.dest_right = $urandom;
		return r;
	endfunction

	function automatic int draw_gap_limit();
		case ($urandom_range(0, 2))
			0:       return 0;
			1:       return 3;
			default: return GAP_LIMIT;
		endcase
	endfunction

	function automatic logic [15:0] pick_volume();
		case ($urandom_range(0, 3))
			0:       return '0;
			1:       return '1;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic signed [22:0] pick_ramp_step();
		case ($urandom_range(0, 4))
			0:       return 23'h3FFFFF;
			1:       return 23'h400000;
			2:       return 23'($urandom_range(0, 4095)) - 23'd2048;
			default: return 23'($urandom);
		endcase
	endfunction

	function automatic voice_cfg_t random_cfg();
		voice_cfg_t c;
		longint     s;
		c.mode = 2'($urandom);
		c.interp = 1'($urandom);
		c.declick = 1'($urandom);
		case ($urandom_range(0, 5))
			0: c.step = 44'h800_0000_0000;
			1: c.step = 44'h7FF_FFFF_FFFF;
			2: c.step = {12'($urandom), $urandom};
			default: begin
				// at most one word either way
				s = longint'($urandom_range(0, 1 << 20)) - (longint'(1) << 19);
				c.step = 44'(s <<< 13);
			end
		endcase
		c.lvol = pick_volume();
		c.rvol = pick_volume();
		c.lramp_step = pick_ramp_step();
		c.rramp_step = pick_ramp_step();
		return c;
	endfunction

	task automatic send_request(input logic [1:0] op, input voice_req_t req);
		int gap;
		gap = $urandom_range(0, tx_gap_max);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= req;
		do @(posedge clk); while (!s_tready);
		apply_voice_request(op, req);
	endtask

	// a mix only ever reads words that were loaded before
	task automatic ensure_word(input logic [11:0] addr);
		voice_req_t req;
		if (!word_written[addr]) begin
			req = random_req();
			req.addr = addr;
			send_request(rvm_pkg::OP_LOAD, req);
		end
	endtask

	task automatic send_mix(input logic [31:0] dl, input logic [31:0] dr);
		voice_req_t req;
		ensure_word(voice_pos[43:32]);
		ensure_word(voice_pos[43:32] + 12'd1);
		req = random_req();
		req.dest_left = dl;
		req.dest_right = dr;
		send_request(rvm_pkg::OP_MIX, req);
	endtask

	task automatic send_random_item();
		voice_req_t req;
		int         pick;
		req = random_req();
		pick = $urandom_range(0, 99);
		if (pick < 55) begin
			send_mix(req.dest_left, req.dest_right);
		end else if (pick < 75) begin
			if ($urandom_range(0, 7) == 0)
				req.sample = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
			send_request(rvm_pkg::OP_LOAD, req);
		end else if (pick < 95) begin
			if ($urandom_range(0, 7) == 0)
				req.start_pos = $urandom_range(0, 1) ? {44{1'b1}} : {44{1'b0}};
			send_request(rvm_pkg::OP_START, req);
		end else begin
			send_request(OP_UNUSED, req);
		end
	endtask

	task automatic drain_voice();
		s_tvalid <= 1'b0;
		while (expected_mix_q.size() != 0) @(posedge clk);
		// loads and starts leave no result behind, give them time to settle
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apply_settings(input voice_cfg_t c);
		drain_voice();
		cfg_we <= 1'b1;
		cfg_index <= rvm_pkg::CFG_MIX_MODE;
		cfg_data <= 44'(c.mode);
		@(posedge clk);
		cfg_index <= rvm_pkg::CFG_INTERPOLATE;
		cfg_data <= 44'(c.interp);
		@(posedge clk);
		cfg_index <= rvm_pkg::CFG_DECLICK;
		cfg_data <= 44'(c.declick);
		@(posedge clk);
		cfg_index <= rvm_pkg::CFG_STEP_INCREMENT;
		cfg_data <= c.step;
		@(posedge clk);
		cfg_index <= rvm_pkg::CFG_LEFT_VOLUME;
		cfg_data <= 44'(c.lvol);
		@(posedge clk);
		cfg_index <= rvm_pkg::CFG_RIGHT_VOLUME;
		cfg_data <= 44'(c.rvol);
		@(posedge clk);
		cfg_index <= rvm_pkg::CFG_LEFT_RAMP_STEP;
		cfg_data <= 44'(c.lramp_step);
		@(posedge clk);
		cfg_index <= rvm_pkg::CFG_RIGHT_RAMP_STEP;
		cfg_data <= 44'(c.rramp_step);
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_cfg = c;
	endtask

	// registers left at their reset values
	task automatic test_reset_defaults();
		tx_gap_max = 3;
		rx_gap_max = 3;
		repeat (3) send_mix($urandom, $urandom);
	endtask

	task automatic test_field_extremes();
		voice_cfg_t c;
		voice_req_t req;
		tx_gap_max = draw_gap_limit();
		rx_gap_max = draw_gap_limit();
		c = cur_cfg;
		c.mode = rvm_pkg::MODE_STEREO;
		c.interp = 1'b1;
		c.declick = 1'b0;
		c.step = rvm_pkg::STEP_RESET;
		c.lvol = '1;
		c.rvol = '1;
		c.lramp_step = '0;
		c.rramp_step = '0;
		apply_settings(c);
		req = random_req();
		req.addr = '0;
		req.sample = 16'sh8000;
		send_request(rvm_pkg::OP_LOAD, req);
		req = random_req();
		req.addr = '1;
		req.sample = 16'sh7FFF;
		send_request(rvm_pkg::OP_LOAD, req);
		req = random_req();
		req.addr = 12'd1;
		req.sample = 16'sh7FFF;
		send_request(rvm_pkg::OP_LOAD, req);
		// last word interpolates toward word zero, accumulators overflow
		req = random_req();
		req.start_pos = '1;
		req.start_lvol = 23'h400000;
		req.start_rvol = 23'h3FFFFF;
		send_request(rvm_pkg::OP_START, req);
		send_mix(32'h7FFF_FFFF, 32'h8000_0000);
		send_mix('0, '0);
		send_request(OP_UNUSED, random_req());
		req = random_req();
		req.start_pos = '0;
		req.start_lvol = '0;
		req.start_rvol = '0;
		send_request(rvm_pkg::OP_START, req);
		send_mix('1, 32'h7FFF_FFFF);
		// ramp volumes run past their 23-bit range, position steps back a word
		c.declick = 1'b1;
		c.lramp_step = 23'h3FFFFF;
		c.rramp_step = 23'h400000;
		c.step = 44'hFFF_0000_0000;
		apply_settings(c);
		req = random_req();
		req.start_pos = 44'h000_8000_0000;
		req.start_lvol = 23'h3FFFF0;
		req.start_rvol = 23'h400008;
		send_request(rvm_pkg::OP_START, req);
		repeat (3) send_mix($urandom, $urandom);
		c.step = 44'h800_0000_0000;
		c.mode = rvm_pkg::MODE_MONO;
		apply_settings(c);
		repeat (2) send_mix($urandom, $urandom);
		c.step = 44'h7FF_FFFF_FFFF;
		c.mode = rvm_pkg::MODE_SURROUND;
		apply_settings(c);
		repeat (2) send_mix($urandom, $urandom);
	endtask

	task automatic test_mix_modes();
		logic [1:0] mode_list [4];
		voice_cfg_t c;
		mode_list = '{rvm_pkg::MODE_MONO, rvm_pkg::MODE_STEREO, rvm_pkg::MODE_SURROUND,
			MODE_SURROUND_ALT};
		foreach (mode_list[m]) begin
			for (int ip = 0; ip < 2; ip++) begin
				for (int dc = 0; dc < 2; dc++) begin
					c = random_cfg();
					c.mode = mode_list[m];
					c.interp = ip[0];
					c.declick = dc[0];
					apply_settings(c);
					tx_gap_max = draw_gap_limit();
					rx_gap_max = draw_gap_limit();
					send_request(rvm_pkg::OP_START, random_req());
					repeat (10) send_random_item();
				end
			end
		end
	endtask

	task automatic test_random_settings();
		repeat (8) begin
			apply_settings(random_cfg());
			tx_gap_max = draw_gap_limit();
			rx_gap_max = draw_gap_limit();
			repeat (25) send_random_item();
		end
	endtask

	// output held off long enough for the block to stall its input
	task automatic test_output_backpressure();
		voice_cfg_t c;
		c = random_cfg();
		c.mode = rvm_pkg::MODE_STEREO;
		apply_settings(c);
		tx_gap_max = 0;
		rx_gap_max = 0;
		rx_hold_on = 1'b1;
		repeat (30) send_mix($urandom, $urandom);
	endtask

	// counts the cycles of the long receiver hold
	always @(posedge clk) begin
		if (rx_hold_on && rx_hold_count < HOLD_CYCLES)
			rx_hold_count <= rx_hold_count + 1;
	end

	initial begin : result_sink
		int gap;
		wait (arst_n);
		forever begin
			gap = $urandom_range(0, rx_gap_max);
			if (gap > 0 || (rx_hold_on && rx_hold_count < HOLD_CYCLES)) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
				while (rx_hold_on && rx_hold_count < HOLD_CYCLES) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	always @(posedge clk) begin : result_check
		mix_out_t got;
		mix_out_t want;
		if (m_tvalid && m_tready) begin
			got = m_tdata;
			if (expected_mix_q.size() == 0) begin
				report_error($sformatf("result %h with no request pending", m_tdata));
			end else begin
				want = expected_mix_q.pop_front();
				if (got.mixed_left !== want.mixed_left)
					report_error($sformatf("mixed_left %h, want %h",
						got.mixed_left, want.mixed_left));
				if (got.mixed_right !== want.mixed_right)
					report_error($sformatf("mixed_right %h, want %h",
						got.mixed_right, want.mixed_right));
			end
		end
	end

	initial begin : watchdog
		#3000000;
		$display("*** FAILED ***");
		$finish;
	end

	initial begin : main_sequence
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_field_extremes();
		test_mix_modes();
		test_output_backpressure();
		test_random_settings();
		drain_voice();
		if (error_count == 0 && expected_mix_q.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
